// ===== rtl/core/pls_pkg.sv =====
package pls_pkg;

  localparam int unsigned DEPTH_DEF = 64;

  localparam int unsigned OP_W     = 4;
  localparam int unsigned POS_W    = 7;
  localparam int unsigned WORD_W   = 32;
  localparam int unsigned COUNT_W  = 7;
  localparam int unsigned STATUS_W = 2;

  typedef enum logic [OP_W-1:0] {
    OP_PREPEND     = 4'd0,
    OP_APPEND      = 4'd1,
    OP_INSERT_AT   = 4'd2,
    OP_REMOVE_HEAD = 4'd3,
    OP_REMOVE_TAIL = 4'd4,
    OP_REMOVE_AT   = 4'd5,
    OP_READ_AT     = 4'd6,
    OP_READ_HEAD   = 4'd7,
    OP_READ_TAIL   = 4'd8,
    OP_CLEAR       = 4'd9
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_RANGE = 2'd2,
    STAT_FULL  = 2'd3
  } status_t;

  // per-cycle command broadcast to every cell
  typedef struct packed {
    logic ins;    // open a gap at the target position
    logic del;    // close the gap at the target position
    logic snap;   // copy data into the read chain
    logic shift;  // move the read chain one cell toward the head
  } cell_ctl_t;

endpackage

// ===== rtl/core/pls_cell.sv =====
module pls_cell #(
  parameter int unsigned IW = 6,
  parameter int unsigned K  = 0
) (
  input  logic                          clk,
  input  pls_pkg::cell_ctl_t            ctl,
  input  logic [IW-1:0]                 at,
  input  logic [pls_pkg::WORD_W-1:0]    word,
  input  logic [pls_pkg::WORD_W-1:0]    left_data,
  input  logic [pls_pkg::WORD_W-1:0]    right_data,
  input  logic [pls_pkg::WORD_W-1:0]    right_pass,
  output logic [pls_pkg::WORD_W-1:0]    data,
  output logic [pls_pkg::WORD_W-1:0]    pass
);

  localparam logic [IW-1:0] MY_IDX = IW'(K);

  logic [pls_pkg::WORD_W-1:0] data_r, data_nxt;
  logic [pls_pkg::WORD_W-1:0] pass_r, pass_nxt;

  always_comb begin
    data_nxt = data_r;
    if (ctl.ins) begin
      if (MY_IDX > at) begin
        data_nxt = left_data;
      end else if (MY_IDX == at) begin
        data_nxt = word;
      end
    end else if (ctl.del) begin
      if (MY_IDX >= at) begin
        data_nxt = right_data;
      end
    end
  end

  always_comb begin
    pass_nxt = pass_r;
    if (ctl.snap) begin
      pass_nxt = data_r;
    end else if (ctl.shift) begin
      pass_nxt = right_pass;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
    pass_r <= pass_nxt;
  end

  assign data = data_r;
  assign pass = pass_r;

endmodule

// ===== rtl/core/positional_list_store_unit.sv =====
// Channel  Direction  Ports                                       Handshake
// -------  ---------  ------------------------------------------  -----------------
// in       input      in_operation, in_position, in_value          in_valid/in_stall
// out      output     out_read_value, out_count, out_status        out_valid/out_stall
//
// Edits (insert/remove/clear) need no sequencing: every cell loads from its
// neighbor at once, so the result appears the cycle after the transfer.
// Reads snapshot the cells into a read chain that moves one cell toward the
// head per cycle; a read at position p shifts until cell 0 holds that element.
// A new request is taken while the previous result is being transferred out.
// rst_n (synchronous) empties the list; cell contents are left as they are.
// out_stall holds the result register and stalls the input side.
module positional_list_store_unit #(
  parameter int unsigned DEPTH = pls_pkg::DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [pls_pkg::OP_W-1:0]        in_operation,
  input  logic [pls_pkg::POS_W-1:0]       in_position,
  input  logic signed [pls_pkg::WORD_W-1:0] in_value,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic signed [pls_pkg::WORD_W-1:0] out_read_value,
  output logic [pls_pkg::COUNT_W-1:0]     out_count,
  output logic [pls_pkg::STATUS_W-1:0]    out_status
);

  localparam int unsigned IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;  // cell index
  localparam int unsigned LW = $clog2(DEPTH + 1);                 // element count
  // common compare width for position vs. length
  localparam int unsigned CW = (LW > pls_pkg::POS_W) ? LW : pls_pkg::POS_W;

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_SHIFT = 3'b010,
    S_OUT   = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  logic [LW-1:0] length_r, length_nxt;
  logic [IW-1:0] cnt_r, cnt_nxt;

  logic [pls_pkg::WORD_W-1:0]   out_rv_r, out_rv_nxt;
  logic [pls_pkg::COUNT_W-1:0]  out_count_r, out_count_nxt;
  logic [pls_pkg::STATUS_W-1:0] out_status_r, out_status_nxt;

  // ---------------------------------------------------------------------------
  // Request decode
  // ---------------------------------------------------------------------------
  logic                 take;       // input transfer this cycle
  logic                 out_done;   // result transfer this cycle
  pls_pkg::op_t         op;
  pls_pkg::status_t     status;
  logic                 do_ins, do_del, do_rd, do_clr;
  logic [IW-1:0]        at;
  logic [CW-1:0]        pos_w, len_w, cnt_w;
  logic                 empty, full;
  pls_pkg::cell_ctl_t   ctl;

  assign out_done = (state_r == S_OUT) && !out_stall;
  assign in_stall = !((state_r == S_IDLE) || out_done);
  assign take     = in_valid && !in_stall;

  assign op    = pls_pkg::op_t'(in_operation);
  assign pos_w = CW'(in_position);
  assign len_w = CW'(length_r);
  assign empty = (length_r == '0);
  assign full  = (length_r == LW'(DEPTH));

  always_comb begin
    status = pls_pkg::STAT_OK;
    do_ins = 1'b0;
    do_del = 1'b0;
    do_rd  = 1'b0;
    do_clr = 1'b0;
    at     = '0;
    unique case (op)
      pls_pkg::OP_PREPEND: begin
        if (full) status = pls_pkg::STAT_FULL;
        else do_ins = 1'b1;
      end
      pls_pkg::OP_APPEND: begin
        at = IW'(length_r);
        if (full) status = pls_pkg::STAT_FULL;
        else do_ins = 1'b1;
      end
      pls_pkg::OP_INSERT_AT: begin
        at = pos_w[IW-1:0];
        if (pos_w > len_w) status = pls_pkg::STAT_RANGE;
        else if (full) status = pls_pkg::STAT_FULL;
        else do_ins = 1'b1;
      end
      pls_pkg::OP_REMOVE_HEAD: begin
        if (empty) status = pls_pkg::STAT_EMPTY;
        else do_del = 1'b1;
      end
      pls_pkg::OP_REMOVE_TAIL: begin
        at = IW'(length_r - 1'b1);
        if (empty) status = pls_pkg::STAT_EMPTY;
        else do_del = 1'b1;
      end
      pls_pkg::OP_REMOVE_AT: begin
        at = pos_w[IW-1:0];
        if (empty) status = pls_pkg::STAT_EMPTY;
        else if (pos_w >= len_w) status = pls_pkg::STAT_RANGE;
        else do_del = 1'b1;
      end
      pls_pkg::OP_READ_AT: begin
        at = pos_w[IW-1:0];
        if (empty) status = pls_pkg::STAT_EMPTY;
        else if (pos_w >= len_w) status = pls_pkg::STAT_RANGE;
        else do_rd = 1'b1;
      end
      pls_pkg::OP_READ_HEAD: begin
        if (empty) status = pls_pkg::STAT_EMPTY;
        else do_rd = 1'b1;
      end
      pls_pkg::OP_READ_TAIL: begin
        at = IW'(length_r - 1'b1);
        if (empty) status = pls_pkg::STAT_EMPTY;
        else do_rd = 1'b1;
      end
      pls_pkg::OP_CLEAR: begin
        do_clr = 1'b1;
      end
      default: begin
        // unused codes: no change, status ok
      end
    endcase
  end

  always_comb begin
    length_nxt = length_r;
    if (take) begin
      if (do_clr) length_nxt = '0;
      else if (do_ins) length_nxt = length_r + 1'b1;
      else if (do_del) length_nxt = length_r - 1'b1;
    end
  end

  assign cnt_w = CW'(length_nxt);

  assign ctl.ins   = take && do_ins;
  assign ctl.del   = take && do_del;
  assign ctl.snap  = take && do_rd;
  assign ctl.shift = (state_r == S_SHIFT) && (cnt_r != '0);

  // ---------------------------------------------------------------------------
  // Cell chain: cell k holds the element at position k
  // ---------------------------------------------------------------------------
  logic [pls_pkg::WORD_W-1:0] cell_data [DEPTH];
  logic [pls_pkg::WORD_W-1:0] cell_pass [DEPTH];

  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    logic [pls_pkg::WORD_W-1:0] left_d, right_d, right_p;
    if (k == 0) begin : g_head
      assign left_d = in_value;
    end else begin : g_mid_l
      assign left_d = cell_data[k-1];
    end
    if (k == DEPTH - 1) begin : g_tail
      assign right_d = cell_data[k];
      assign right_p = cell_pass[k];
    end else begin : g_mid_r
      assign right_d = cell_data[k+1];
      assign right_p = cell_pass[k+1];
    end
    pls_cell #(
      .IW (IW),
      .K  (k)
    ) u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .at         (at),
      .word       (in_value),
      .left_data  (left_d),
      .right_data (right_d),
      .right_pass (right_p),
      .data       (cell_data[k]),
      .pass       (cell_pass[k])
    );
  end

  // ---------------------------------------------------------------------------
  // Sequencer and result register
  // ---------------------------------------------------------------------------
  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    out_rv_nxt     = out_rv_r;
    out_count_nxt  = out_count_r;
    out_status_nxt = out_status_r;
    unique case (state_r)
      S_IDLE, S_OUT: begin
        if (take) begin
          out_count_nxt  = cnt_w[pls_pkg::COUNT_W-1:0];
          out_status_nxt = status;
          out_rv_nxt     = '0;
          if (do_rd) begin
            cnt_nxt   = at;
            state_nxt = S_SHIFT;
          end else begin
            state_nxt = S_OUT;
          end
        end else if (out_done) begin
          state_nxt = S_IDLE;
        end
      end
      S_SHIFT: begin
        if (cnt_r == '0) begin
          out_rv_nxt = cell_pass[0];
          state_nxt  = S_OUT;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      length_r <= '0;
      cnt_r    <= '0;
    end else begin
      state_r  <= state_nxt;
      length_r <= length_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_rv_r     <= out_rv_nxt;
    out_count_r  <= out_count_nxt;
    out_status_r <= out_status_nxt;
  end

  assign out_valid      = (state_r == S_OUT);
  assign out_read_value = out_rv_r;
  assign out_count      = out_count_r;
  assign out_status     = out_status_r;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    length_r <= LW'(DEPTH))
    else $error("length above DEPTH");

  a_shift_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SHIFT) |-> in_stall)
    else $error("input taken during read shift");

  a_cnt_dec: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SHIFT && cnt_r != '0) |=> (cnt_r == $past(cnt_r) - 1'b1))
    else $error("read countdown skipped");

  a_edit_result: assert property (@(posedge clk) disable iff (!rst_n)
    (take && !do_rd) |=> (out_valid && out_read_value == '0))
    else $error("edit result missing or nonzero read value");

  a_count_match: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (CW'(out_count) == CW'(cnt_w[pls_pkg::COUNT_W-1:0]) || take))
    else $error("reported count disagrees with length");

endmodule

// ===== verif/tb_top.sv =====
module tb_top;

  localparam int unsigned LIST_DEPTH = pls_pkg::DEPTH_DEF;

  // operation codes the block ignores
  localparam logic [pls_pkg::OP_W-1:0] OP_UNUSED_LO = 4'd10;
  localparam logic [pls_pkg::OP_W-1:0] OP_UNUSED_HI = 4'd15;

  // reads walk a chain of up to DEPTH cells; leave room at the end
  localparam int unsigned DRAIN_CYCLES = LIST_DEPTH + 40;

  localparam logic signed [pls_pkg::WORD_W-1:0] WORD_MIN = 32'sh8000_0000;
  localparam logic signed [pls_pkg::WORD_W-1:0] WORD_MAX = 32'sh7fff_ffff;

  typedef struct {
    logic signed [pls_pkg::WORD_W-1:0] read_value;
    logic [pls_pkg::COUNT_W-1:0]       count;
    pls_pkg::status_t                  status;
  } list_answer_t;

  logic                                clk;
  logic                                rst_n;
  logic                                in_valid;
  logic                                in_stall;
  logic [pls_pkg::OP_W-1:0]            in_operation;
  logic [pls_pkg::POS_W-1:0]           in_position;
  logic signed [pls_pkg::WORD_W-1:0]   in_value;
  logic                                out_valid;
  logic                                out_stall;
  logic signed [pls_pkg::WORD_W-1:0]   out_read_value;
  logic [pls_pkg::COUNT_W-1:0]         out_count;
  logic [pls_pkg::STATUS_W-1:0]        out_status;

  // shadow copy of the list, updated as each request transfers in
  logic signed [pls_pkg::WORD_W-1:0]   shadow_cells [LIST_DEPTH];
  int unsigned                         shadow_len;

  list_answer_t               pending_answers [$];
  list_answer_t               oldest_answer;
  int unsigned                error_count;
  int unsigned                sent_count;
  int unsigned                taken_count;

  positional_list_store_unit #(
    .DEPTH(LIST_DEPTH)
  ) i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_operation   (in_operation),
    .in_position    (in_position),
    .in_value       (in_value),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_read_value (out_read_value),
    .out_count      (out_count),
    .out_status     (out_status)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // hard stop in case the block hangs
  initial begin
    #1_500_000;
    $display("simulation failed");
    $finish;
  end

  // Update the shadow list for one request and queue the answer the block
  // must give. Errors leave the list untouched; insert_at checks the range
  // before fullness, indexed remove/read check emptiness before range.
  task automatic apply_request(input logic [pls_pkg::OP_W-1:0] op,
                               input logic [pls_pkg::POS_W-1:0] pos,
                               input logic signed [pls_pkg::WORD_W-1:0] word);
    list_answer_t ans;
    int unsigned  slot;
    int unsigned  k;
    ans.read_value = '0;
    ans.status     = pls_pkg::STAT_OK;
    slot           = 0;
    case (op)
      pls_pkg::OP_PREPEND, pls_pkg::OP_APPEND, pls_pkg::OP_INSERT_AT: begin
        if (op == pls_pkg::OP_APPEND) slot = shadow_len;
        if (op == pls_pkg::OP_INSERT_AT) slot = 32'(pos);
        if (op == pls_pkg::OP_INSERT_AT && 32'(pos) > shadow_len) begin
          ans.status = pls_pkg::STAT_RANGE;
        end else if (shadow_len >= LIST_DEPTH) begin
          ans.status = pls_pkg::STAT_FULL;
        end else begin
          for (k = shadow_len; k > slot; k--) shadow_cells[k] = shadow_cells[k-1];
          shadow_cells[slot] = word;
          shadow_len++;
        end
      end
      pls_pkg::OP_REMOVE_HEAD, pls_pkg::OP_REMOVE_TAIL, pls_pkg::OP_REMOVE_AT,
      pls_pkg::OP_READ_AT, pls_pkg::OP_READ_HEAD, pls_pkg::OP_READ_TAIL: begin
        if (op == pls_pkg::OP_REMOVE_AT || op == pls_pkg::OP_READ_AT) slot = 32'(pos);
        if (op == pls_pkg::OP_REMOVE_TAIL || op == pls_pkg::OP_READ_TAIL)
          slot = shadow_len - 1;
        if (shadow_len == 0) begin
          ans.status = pls_pkg::STAT_EMPTY;
        end else if (slot >= shadow_len) begin
          ans.status = pls_pkg::STAT_RANGE;
        end else if (op == pls_pkg::OP_READ_AT || op == pls_pkg::OP_READ_HEAD ||
                     op == pls_pkg::OP_READ_TAIL) begin
          ans.read_value = shadow_cells[slot];
        end else begin
          for (k = slot; k + 1 < shadow_len; k++) shadow_cells[k] = shadow_cells[k+1];
          shadow_len--;
        end
      end
      pls_pkg::OP_CLEAR: begin
        shadow_len = 0;
      end
      default: begin
      end
    endcase
    ans.count = pls_pkg::COUNT_W'(shadow_len);
    pending_answers.push_back(ans);
  endtask

  // One request transfer. Every fourth stretch of 80 requests goes back to back.
  task automatic send_request(input logic [pls_pkg::OP_W-1:0] op,
                              input logic [pls_pkg::POS_W-1:0] pos,
                              input logic signed [pls_pkg::WORD_W-1:0] word);
    int unsigned gap;
    gap = ((sent_count / 80) % 4 == 3) ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_operation <= op;
    in_position  <= pos;
    in_value     <= word;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    apply_request(op, pos, word);
    sent_count++;
  endtask

  function automatic logic signed [pls_pkg::WORD_W-1:0] pick_word();
    case ($urandom_range(0, 15))
      0: pick_word = WORD_MIN;
      1: pick_word = WORD_MAX;
      2: pick_word = '0;
      3: pick_word = -1;
      default: pick_word = $urandom;
    endcase
  endfunction

  task automatic check_field(input string name, input logic [pls_pkg::WORD_W-1:0] want,
                             input logic [pls_pkg::WORD_W-1:0] got);
    if (want !== got) begin
      $display("%0t %s mismatch: expected %h, actual %h", $time, name, want, got);
      error_count++;
    end
  endtask

  // result side: compare each transfer with the oldest queued answer
  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (pending_answers.size() == 0) begin
        $display("%0t unexpected result: expected none, actual value %h count %0d status %0d",
                 $time, out_read_value, out_count, out_status);
        error_count++;
      end else begin
        oldest_answer = pending_answers.pop_front();
        check_field("read_value", oldest_answer.read_value, out_read_value);
        check_field("count", pls_pkg::WORD_W'(oldest_answer.count),
                    pls_pkg::WORD_W'(out_count));
        check_field("status", pls_pkg::WORD_W'(oldest_answer.status),
                    pls_pkg::WORD_W'(out_status));
      end
    end
  end

  // result-side back-pressure: a random hold before each transfer,
  // with one stretch in four of 70 results taken without holding
  initial begin
    int unsigned hold;
    out_stall <= 1'b0;
    do @(posedge clk); while (rst_n !== 1'b1);
    forever begin
      hold = ((taken_count / 70) % 4 == 1) ? 0 : $urandom_range(0, 15);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (out_valid !== 1'b1) @(posedge clk);
      taken_count++;
    end
  end

  // empty-list errors, word extremes, range errors, unused codes, clear
  task automatic test_corner_requests();
    send_request(pls_pkg::OP_READ_HEAD, '0, '0);
    send_request(pls_pkg::OP_READ_TAIL, '0, '0);
    send_request(pls_pkg::OP_READ_AT, '0, '0);
    send_request(pls_pkg::OP_REMOVE_HEAD, '0, '0);
    send_request(pls_pkg::OP_REMOVE_TAIL, '0, '0);
    send_request(pls_pkg::OP_REMOVE_AT, '0, '0);
    send_request(pls_pkg::OP_INSERT_AT, 7'd1, 32'sd5);
    send_request(pls_pkg::OP_INSERT_AT, 7'd0, WORD_MIN);
    send_request(pls_pkg::OP_APPEND, 7'd127, WORD_MAX);
    send_request(pls_pkg::OP_PREPEND, 7'd64, -32'sd1);
    send_request(pls_pkg::OP_INSERT_AT, 7'd3, '0);
    send_request(pls_pkg::OP_INSERT_AT, 7'd2, 32'sh5a5a_5a5a);
    send_request(pls_pkg::OP_READ_AT, 7'd2, '0);
    send_request(pls_pkg::OP_READ_AT, 7'd127, '0);
    send_request(pls_pkg::OP_READ_AT, 7'd5, '0);
    send_request(pls_pkg::OP_READ_HEAD, 7'd127, -32'sd1);
    send_request(pls_pkg::OP_READ_TAIL, 7'd0, '0);
    send_request(pls_pkg::OP_REMOVE_AT, 7'd5, '0);
    send_request(pls_pkg::OP_REMOVE_AT, 7'd1, '0);
    send_request(pls_pkg::OP_REMOVE_HEAD, 7'd3, '0);
    send_request(pls_pkg::OP_REMOVE_TAIL, 7'd0, '0);
    send_request(OP_UNUSED_LO, 7'd0, WORD_MAX);
    send_request(OP_UNUSED_HI, 7'd127, WORD_MIN);
    send_request(pls_pkg::OP_CLEAR, 7'd3, -32'sd1);
    send_request(pls_pkg::OP_READ_AT, 7'd0, '0);
  endtask

  // fill to capacity, push against the full list, then drain past empty
  task automatic test_fill_and_drain();
    logic [pls_pkg::OP_W-1:0] op;
    send_request(pls_pkg::OP_CLEAR, '0, '0);
    while (shadow_len < LIST_DEPTH) begin
      op = pls_pkg::OP_W'($urandom_range(pls_pkg::OP_PREPEND, pls_pkg::OP_INSERT_AT));
      send_request(op, pls_pkg::POS_W'($urandom_range(0, shadow_len)), pick_word());
      if ($urandom_range(0, 7) == 0)
        send_request(pls_pkg::OP_READ_AT,
                     pls_pkg::POS_W'($urandom_range(0, shadow_len - 1)), '0);
    end
    send_request(pls_pkg::OP_PREPEND, '0, pick_word());
    send_request(pls_pkg::OP_APPEND, '0, pick_word());
    send_request(pls_pkg::OP_INSERT_AT, 7'd64, pick_word());
    send_request(pls_pkg::OP_INSERT_AT, 7'd65, pick_word());
    send_request(pls_pkg::OP_INSERT_AT, 7'd127, pick_word());
    send_request(pls_pkg::OP_READ_AT, 7'd63, '0);
    send_request(pls_pkg::OP_READ_AT, 7'd64, '0);
    send_request(pls_pkg::OP_READ_HEAD, '0, '0);
    send_request(pls_pkg::OP_READ_TAIL, '0, '0);
    send_request(pls_pkg::OP_REMOVE_AT, 7'd64, '0);
    send_request(pls_pkg::OP_REMOVE_AT, 7'd63, '0);
    while (shadow_len > 0) begin
      op = pls_pkg::OP_W'($urandom_range(pls_pkg::OP_REMOVE_HEAD, pls_pkg::OP_REMOVE_AT));
      send_request(op, pls_pkg::POS_W'($urandom_range(0, shadow_len - 1)), pick_word());
      if ($urandom_range(0, 5) == 0)
        send_request(pls_pkg::OP_W'($urandom_range(pls_pkg::OP_READ_AT,
                                                   pls_pkg::OP_READ_TAIL)),
                     pls_pkg::POS_W'($urandom_range(0, shadow_len)), '0);
    end
    send_request(pls_pkg::OP_REMOVE_TAIL, '0, '0);
    send_request(pls_pkg::OP_REMOVE_AT, 7'd0, '0);
  endtask

  // Mixed traffic. Phases of 150 requests lean toward growing or shrinking
  // so the list swings between empty and full; most positions are in range.
  task automatic test_random_traffic();
    int unsigned              i;
    int unsigned              pick;
    bit                       grow;
    logic [pls_pkg::OP_W-1:0]  op;
    logic [pls_pkg::POS_W-1:0] pos;
    grow = 1'b1;
    for (i = 0; i < 1260; i++) begin
      if (i % 150 == 0) grow = $urandom_range(0, 2) != 0;
      pick = $urandom_range(0, 199);
      if (pick < 5)
        op = pls_pkg::OP_W'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
      else if (pick < 7)
        op = pls_pkg::OP_CLEAR;
      else if (pick < (grow ? 110 : 55))
        op = pls_pkg::OP_W'($urandom_range(pls_pkg::OP_PREPEND, pls_pkg::OP_INSERT_AT));
      else if (pick < 140)
        op = pls_pkg::OP_W'($urandom_range(pls_pkg::OP_REMOVE_HEAD, pls_pkg::OP_REMOVE_AT));
      else
        op = pls_pkg::OP_W'($urandom_range(pls_pkg::OP_READ_AT, pls_pkg::OP_READ_TAIL));
      if ($urandom_range(0, 9) == 0)
        pos = pls_pkg::POS_W'($urandom_range(0, 127));
      else
        pos = pls_pkg::POS_W'($urandom_range(0, shadow_len));
      send_request(op, pos, pick_word());
    end
  endtask

  initial begin
    error_count  = 0;
    sent_count   = 0;
    taken_count  = 0;
    shadow_len   = 0;
    rst_n        <= 1'b0;
    in_valid     <= 1'b0;
    in_operation <= pls_pkg::OP_CLEAR;
    in_position  <= '0;
    in_value     <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    test_corner_requests();
    test_fill_and_drain();
    test_random_traffic();
    in_valid <= 1'b0;

    // let every queued answer come back, then watch for stray results
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_count == 0 && pending_answers.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
